// File: src/est_pkg.sv
// Shared types and constants for the expiring session table.
`timescale 1ns / 1ps
`default_nettype none
package est_pkg;
	localparam int unsigned SlotsDefault = 32;
	localparam int unsigned UserKeyBitsDefault = 16;
	localparam int unsigned TokenBits = 256;
	localparam int unsigned TimeBits = 32;
	localparam int unsigned IndexBits = 5;
	localparam int unsigned UserOutBits = 16;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REVOKE_TOKEN = 2'd2,
		CMD_REVOKE_USER = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;
endpackage
`default_nettype wire

// File: src/est_cell.sv
// One slot of the session table, which holds an entry and passes it to its neighbor.
`timescale 1ns / 1ps
`default_nettype none
module est_cell #(
	parameter int unsigned USER_KEY_BITS = est_pkg::UserKeyBitsDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic shift,
	input  wire logic load,
	input  wire logic kill,
	input  wire logic valid_in,
	input  wire logic [est_pkg::TokenBits-1:0] token_in,
	input  wire logic [USER_KEY_BITS-1:0] user_in,
	input  wire logic [est_pkg::TimeBits-1:0] expiry_in,
	output logic valid_q,
	output logic [est_pkg::TokenBits-1:0] token_q,
	output logic [USER_KEY_BITS-1:0] user_q,
	output logic [est_pkg::TimeBits-1:0] expiry_q
);
	import est_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (shift) begin
			valid_q <= valid_in && !kill;
		end
	end

	always_ff @(posedge clk) begin
		if (load || shift) begin
			token_q <= token_in;
			user_q <= user_in;
			expiry_q <= expiry_in;
		end
	end
endmodule
`default_nettype wire

// File: src/expiring_session_table.sv
// Top level of the expiring session table: a rotating ring of slot cells and its control.
// Each command rotates the ring once past the examining head cell, then writes a create and
// registers the result in the last scan step, and presents the result in the done state.
// A new command is taken in the cycle after the previous result has been taken, so commands
// never overlap: the rotation, the result and the idle state all lie between two of them.
// Reset empties the table at once; entry contents are left as they were.
`timescale 1ns / 1ps
`default_nettype none
module expiring_session_table #(
	parameter int unsigned SLOTS = est_pkg::SlotsDefault,
	parameter int unsigned USER_KEY_BITS = est_pkg::UserKeyBitsDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// command[1:0], token_word0..3[257:2], user_key[273:258], now_time[305:274],
	// lifetime[337:306], zero fill to 344 bits.
	input  wire logic [343:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// status[0], found_user[16:1], slot_index[21:17], zero fill to 24 bits.
	output logic [23:0] m_axis_tdata
);
	import est_pkg::*;

	localparam int unsigned SlotBits = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CntBits = $clog2(SLOTS + 1);

	state_t state_q;
	cmd_t cmd_q;
	logic [TokenBits-1:0] token_q;
	logic [USER_KEY_BITS-1:0] user_q;
	logic [TimeBits-1:0] now_q;
	logic [TimeBits-1:0] expiry_new_q;
	logic [CntBits-1:0] cnt_q;
	logic hit_q;
	logic free_q;
	logic [SlotBits-1:0] pick_q;
	logic [TimeBits-1:0] best_exp_q;
	logic [USER_KEY_BITS-1:0] found_q;
	logic status_q;
	logic [SlotBits-1:0] idx_q;
	logic reject_q;

	logic [SLOTS-1:0] cv;
	logic [TokenBits-1:0] ctok [SLOTS];
	logic [USER_KEY_BITS-1:0] cuser [SLOTS];
	logic [TimeBits-1:0] cexp [SLOTS];
	logic [SLOTS-1:0] cload;
	logic shift, head_kill;

	logic [15:0] in_user_raw;
	logic [USER_KEY_BITS-1:0] in_user;
	logic [TimeBits:0] sum;
	logic [SlotBits-1:0] pos;
	logic head_live, head_tok, head_expired;

	assign in_user_raw = s_axis_tdata[273:258];
	assign in_user = USER_KEY_BITS'(in_user_raw);
	assign sum = {1'b0, s_axis_tdata[305:274]} + {1'b0, s_axis_tdata[337:306]};

	assign s_axis_tready = state_q == ST_IDLE;
	assign shift = state_q == ST_SCAN && cnt_q != CntBits'(SLOTS);
	assign pos = cnt_q[SlotBits-1:0];

	// Cell 0 is the head that sees every slot in turn; it rotates into the last cell.
	assign head_expired = cv[0] && (cmd_q == CMD_CREATE || cmd_q == CMD_LOOKUP) &&
		cexp[0] <= now_q;
	assign head_live = cv[0] && !head_expired;
	assign head_tok = ctok[0] == token_q;
	always_comb begin
		head_kill = head_expired;
		unique case (cmd_q)
			CMD_REVOKE_TOKEN: if (head_live && head_tok) head_kill = 1'b1;
			CMD_REVOKE_USER: if (head_live && cuser[0] == user_q) head_kill = 1'b1;
			default: ;
		endcase
		if (reject_q) head_kill = 1'b0;
	end

	always_comb begin
		cload = '0;
		if (state_q == ST_SCAN && cnt_q == CntBits'(SLOTS) && cmd_q == CMD_CREATE && !reject_q)
			cload[pick_q] = 1'b1;
	end

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			localparam int unsigned Nx = (g + 1) % SLOTS;
			est_cell #(.USER_KEY_BITS(USER_KEY_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n),
				.shift(shift), .load(cload[g]),
				.kill(g == SLOTS - 1 ? head_kill : 1'b0),
				.valid_in(cv[Nx]),
				.token_in(cload[g] ? token_q : ctok[Nx]),
				.user_in(cload[g] ? user_q : cuser[Nx]),
				.expiry_in(cload[g] ? expiry_new_q : cexp[Nx]),
				.valid_q(cv[g]), .token_q(ctok[g]), .user_q(cuser[g]), .expiry_q(cexp[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid) begin
					state_q <= ST_SCAN;
					cnt_q <= '0;
				end
				ST_SCAN: if (cnt_q == CntBits'(SLOTS)) state_q <= ST_DONE;
					else cnt_q <= cnt_q + 1'b1;
				ST_DONE: if (m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			cmd_q <= cmd_t'(s_axis_tdata[1:0]);
			token_q <= s_axis_tdata[257:2];
			user_q <= in_user;
			now_q <= s_axis_tdata[305:274];
			expiry_new_q <= sum[TimeBits] ? '1 : sum[TimeBits-1:0];
			reject_q <= in_user == '0 && (s_axis_tdata[1:0] == CMD_CREATE ||
				s_axis_tdata[1:0] == CMD_REVOKE_USER);
			hit_q <= 1'b0;
			free_q <= 1'b0;
			pick_q <= '0;
			best_exp_q <= '1;
			found_q <= '0;
		end else if (shift) begin
			if (!head_live && !free_q) begin
				free_q <= 1'b1;
				pick_q <= pos;
			end else if (!free_q && (cnt_q == '0 || cexp[0] < best_exp_q)) begin
				best_exp_q <= cexp[0];
				pick_q <= pos;
			end
			if (cmd_q == CMD_LOOKUP && head_live && head_tok && !hit_q) begin
				hit_q <= 1'b1;
				found_q <= cuser[0];
				idx_q <= pos;
			end
		end else if (state_q == ST_SCAN) begin
			unique case (cmd_q)
				CMD_CREATE: begin
					status_q <= reject_q;
					idx_q <= reject_q ? '0 : pick_q;
				end
				CMD_LOOKUP: begin
					status_q <= !hit_q;
					if (!hit_q) idx_q <= '0;
				end
				CMD_REVOKE_TOKEN: begin
					status_q <= 1'b0;
					idx_q <= '0;
				end
				CMD_REVOKE_USER: begin
					status_q <= reject_q;
					idx_q <= '0;
				end
				default: ;
			endcase
			if (cmd_q != CMD_LOOKUP) found_q <= '0;
		end
	end

	logic [UserOutBits-1:0] found_out;
	logic [IndexBits-1:0] idx_out;
	assign found_out = UserOutBits'(found_q);
	assign idx_out = IndexBits'(idx_q);
	assign m_axis_tvalid = state_q == ST_DONE;
	assign m_axis_tdata = {2'b00, idx_out, found_out, status_q};

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cload)) else $error("more than one slot written");
	a_load_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		cload != '0 |=> m_axis_tvalid) else $error("slot write outside scan end");
`endif
endmodule
`default_nettype wire
